FILE: src/outlier_score_top_k_unit_macros.svh
// Assertion macros for the outlier score top-k unit.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef OUTLIER_SCORE_TOP_K_UNIT_MACROS_SVH
`define OUTLIER_SCORE_TOP_K_UNIT_MACROS_SVH

// clocked check, off while reset is held
`define OSTK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked check, also live during reset
`define OSTK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

FILE: src/ostk_pkg.sv
// Package for the outlier score top-k unit: widths, codes and shared types.
// No dependencies; imported by every module of the block.
package ostk_pkg;

    localparam int WORD_W    = 32;
    localparam int ROW_W     = 32;
    localparam int SCORE_W   = 64;
    localparam int PROD_W    = 64;
    localparam int DEV_W     = 31;
    localparam int MEAS_MAX  = 3;
    localparam int BUDGET_W  = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [DEV_W-1:0]    DEV_MAX    = 31'h7FFF_FFFF;
    localparam logic [BUDGET_W-1:0] BUDGET_RST = 6'd32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_A  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_B  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_C  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 3'd6;

    // command codes (tuser of the input stream)
    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_DRAIN   = 1'b1;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 96;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [SCORE_W-1:0] t_score;
    typedef logic [ROW_W-1:0]   t_row;
    typedef logic [MEAS_MAX-1:0][WORD_W-1:0] t_word_vec;

    // broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   pop;
        t_score score;
        t_row   row;
    } t_cell_cmd;

    // what a cell shows its neighbors and the control
    typedef struct packed {
        logic   keep;   // occupied and not below the new score
        logic   lower;  // occupied and strictly below the new score
        t_score score;
        t_row   row;
    } t_cell_link;

endpackage

FILE: src/ostk_score.sv
// Scoring pipeline: per-measure deviation, saturation, square, then max.
// Depends on ostk_pkg. Four register stages from start to done.
module ostk_score #(
    parameter int NUM_MEASURES = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  ostk_pkg::t_word_vec               i_value,
    input  logic [ostk_pkg::MEAS_MAX-1:0]     i_present,
    input  ostk_pkg::t_word_vec               i_mean,
    input  ostk_pkg::t_word_vec               i_inv,
    output logic                              o_done,
    output ostk_pkg::t_score                  o_best
);
    import ostk_pkg::*;

    logic [3:0]                           r_vld;
    logic [NUM_MEASURES-1:0][WORD_W-1:0]  r_mag;
    logic [NUM_MEASURES-1:0][PROD_W-1:0]  r_prod;
    logic [NUM_MEASURES-1:0][SCORE_W-1:0] r_sq;
    t_score                               r_best;
    t_score                               w_max;

    for (genvar m = 0; m < NUM_MEASURES; m++) begin : g_lane
        logic signed [WORD_W:0] w_diff;
        logic [WORD_W:0]        w_abs;
        logic [DEV_W-1:0]       w_dev;

        always_comb begin
            w_diff = $signed({i_value[m][WORD_W-1], i_value[m]})
                   - $signed({i_mean[m][WORD_W-1], i_mean[m]});
            w_abs  = w_diff[WORD_W] ? $unsigned(-w_diff) : $unsigned(w_diff);
            // saturate the Q15.16 deviation (product bits 63:16)
            w_dev  = (|r_prod[m][PROD_W-1:DEV_W+16]) ? DEV_MAX : r_prod[m][DEV_W+15:16];
        end

        always_ff @(posedge i_clk) begin
            // absent measure or zero scale scores zero
            if (i_start) begin
                r_mag[m] <= (i_present[m] && (i_inv[m] != '0)) ? w_abs[WORD_W-1:0] : '0;
            end
            r_prod[m] <= PROD_W'(r_mag[m]) * PROD_W'(i_inv[m]);
            r_sq[m]   <= SCORE_W'(w_dev) * SCORE_W'(w_dev);
        end
    end

    always_comb begin
        w_max = '0;
        for (int m = 0; m < NUM_MEASURES; m++) begin
            if (r_sq[m] > w_max) begin
                w_max = r_sq[m];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= w_max;
    end

    assign o_done = r_vld[3];
    assign o_best = r_best;

endmodule

FILE: src/ostk_cell.sv
// One cell of the sorted store: holds a score and a row id.
// Depends on ostk_pkg. Inserts by shifting toward the tail, drains toward cell 0.
module ostk_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic                  i_clk,
    input  ostk_pkg::t_cell_cmd   i_cmd,
    input  logic [CW-1:0]         i_count,
    input  ostk_pkg::t_cell_link  i_left,
    input  ostk_pkg::t_cell_link  i_right,
    output ostk_pkg::t_cell_link  o_link
);
    import ostk_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    t_score r_score;
    t_row   r_row;
    logic   w_occ;
    logic   w_keep;

    assign w_occ  = IDX_C < i_count;
    assign w_keep = w_occ && (r_score >= i_cmd.score);

    assign o_link.keep  = w_keep;
    assign o_link.lower = w_occ && !w_keep;
    assign o_link.score = r_score;
    assign o_link.row   = r_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && !w_keep) begin
            // first cell past the kept prefix takes the new entry
            if (i_left.keep) begin
                r_score <= i_cmd.score;
                r_row   <= i_cmd.row;
            end else begin
                r_score <= i_left.score;
                r_row   <= i_left.row;
            end
        end else if (i_cmd.pop) begin
            r_score <= i_right.score;
            r_row   <= i_right.row;
        end
    end

endmodule

FILE: src/outlier_score_top_k_unit.sv
// Top level of the outlier score top-k unit: stream ports, config, control.
// Depends on ostk_pkg, ostk_score, ostk_cell and the assertion macro header.
//
//  channel  | dir | transfer when               | payload
//  ---------+-----+-----------------------------+------------------------------------
//  s_axis   | in  | i_s_axis_tvalid & tready    | tdata row/values/presents, tuser cmd
//  m_axis   | out | o_m_axis_tvalid & tready    | tdata row/score, tuser valid, tlast
//  cfg      | in  | i_cfg_we                    | i_cfg_idx, i_cfg_data
//
// Observe: an accepted transfer passes the scoring pipeline (diff, multiply,
//   saturate+square, max), then the insert; only then is the next one taken.
// Drain: one result per cycle while the sink takes them, one per held entry
//   (one invalid last result if empty); the cell chain shifts once per valid result.
// Reset clears control, the count and the config registers; cells hold no reset value.
// A stalled output holds its result; the next command is taken while the
//   final result of a drain still waits in the output register.
`include "outlier_score_top_k_unit_macros.svh"

module outlier_score_top_k_unit #(
    parameter int CAPACITY     = 32,
    parameter int NUM_MEASURES = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // cfg write port
    input  logic                              i_cfg_we,
    input  logic [ostk_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ostk_pkg::WORD_W-1:0]       i_cfg_data,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [31:0] row_id, [63:32] value_a, [95:64] value_b, [127:96] value_c,
    // [128] present_a, [129] present_b, [130] present_c, [135:131] zero
    input  logic [ostk_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [0] command
    input  logic                              i_s_axis_tuser,
    // output stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [31:0] kept_row, [95:32] kept_score
    output logic [ostk_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // [0] row_valid
    output logic                              o_m_axis_tuser,
    output logic                              o_m_axis_tlast
);
    import ostk_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCORE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // config registers
    t_word_vec             r_mean;
    t_word_vec             r_inv;
    logic [BUDGET_W-1:0]   r_budget;

    // control
    logic [1:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    t_row                  r_row;

    // output register
    logic                  r_out_valid, n_out_valid;
    t_row                  r_out_row;
    t_score                r_out_score;
    logic                  r_out_rv;
    logic                  r_out_last;
    logic                  w_out_load;
    t_row                  w_out_row;
    t_score                w_out_score;
    logic                  w_out_rv;
    logic                  w_out_last;

    // datapath
    logic                  w_accept;
    logic                  w_start;
    logic                  w_done;
    t_score                w_best;
    t_word_vec             w_value;
    logic [MEAS_MAX-1:0]   w_present;
    logic [7:0]            w_bud8;
    logic [CW-1:0]         w_eff;
    logic                  w_any_lower;
    logic                  w_slot;
    t_cell_cmd             w_cmd;
    t_cell_link            w_link [CAPACITY];

    assign w_value[0]  = i_s_axis_tdata[63:32];
    assign w_value[1]  = i_s_axis_tdata[95:64];
    assign w_value[2]  = i_s_axis_tdata[127:96];
    assign w_present   = i_s_axis_tdata[130:128];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_start         = w_accept && (i_s_axis_tuser == CMD_OBSERVE);
    assign w_slot          = !r_out_valid || i_m_axis_tready;

    // budget clipped to the store size
    assign w_bud8 = {2'b00, r_budget};
    assign w_eff  = (w_bud8 > 8'(CAPACITY)) ? CW'(CAPACITY) : CW'(w_bud8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean   <= '0;
            r_inv    <= '0;
            r_budget <= BUDGET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MEAN_A: r_mean[0] <= i_cfg_data;
                CFG_MEAN_B: r_mean[1] <= i_cfg_data;
                CFG_MEAN_C: r_mean[2] <= i_cfg_data;
                CFG_INV_A:  r_inv[0]  <= i_cfg_data;
                CFG_INV_B:  r_inv[1]  <= i_cfg_data;
                CFG_INV_C:  r_inv[2]  <= i_cfg_data;
                CFG_BUDGET: r_budget  <= i_cfg_data[BUDGET_W-1:0];
                default:    ;  // unused index, ignored
            endcase
        end
    end

    ostk_score #(
        .NUM_MEASURES (NUM_MEASURES)
    ) u_score (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_value   (w_value),
        .i_present (w_present),
        .i_mean    (r_mean),
        .i_inv     (r_inv),
        .o_done    (w_done),
        .o_best    (w_best)
    );

    // any occupied cell strictly below the new score means a full store may evict
    always_comb begin
        w_any_lower = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_any_lower = w_any_lower | w_link[i].lower;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        w_cmd.ins   = 1'b0;
        w_cmd.pop   = 1'b0;
        w_cmd.score = w_best;
        w_cmd.row   = r_row;
        w_out_load  = 1'b0;
        w_out_row   = '0;
        w_out_score = '0;
        w_out_rv    = 1'b0;
        w_out_last  = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_s_axis_tuser == CMD_DRAIN) ? ST_DRAIN : ST_SCORE;
                end
            end
            ST_SCORE: begin
                if (w_done) begin
                    n_state = ST_IDLE;
                    if (w_eff != '0 && w_best != '0) begin
                        if (r_count < w_eff) begin
                            w_cmd.ins = 1'b1;
                            n_count   = r_count + 1'b1;
                        end else if (w_any_lower) begin
                            // lowest (newest on ties) falls off the tail
                            w_cmd.ins = 1'b1;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (w_slot) begin
                    w_out_load = 1'b1;
                    if (r_count == '0) begin
                        n_state = ST_IDLE;  // empty store: one invalid last result
                    end else begin
                        w_cmd.pop   = 1'b1;
                        w_out_row   = w_link[0].row;
                        w_out_score = w_link[0].score;
                        w_out_rv    = 1'b1;
                        w_out_last  = (r_count == CW'(1));
                        n_count     = r_count - 1'b1;
                        if (r_count == CW'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_cell_link w_left;
        t_cell_link w_right;

        if (i == 0) begin : g_head
            assign w_left = '{keep: 1'b1, lower: 1'b0, score: '0, row: '0};
        end else begin : g_mid
            assign w_left = w_link[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_link[i+1];
        end

        ostk_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_row <= i_s_axis_tdata[31:0];
        end
        if (w_out_load) begin
            r_out_row   <= w_out_row;
            r_out_score <= w_out_score;
            r_out_rv    <= w_out_rv;
            r_out_last  <= w_out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_score, r_out_row};
    assign o_m_axis_tuser  = r_out_rv;
    assign o_m_axis_tlast  = r_out_last;

    `OSTK_ASSERT(a_empty_is_last, (r_out_valid && !r_out_rv) |-> r_out_last, "empty result not last")
    `OSTK_ASSERT(a_done_in_score, w_done |-> (r_state == ST_SCORE), "score done outside scoring")
    `OSTK_ASSERT(a_pop_needs_slot, w_cmd.pop |-> (w_slot && r_count != '0), "pop without room")
    `OSTK_ASSERT(a_ins_fills, w_cmd.ins |=> (r_count != '0), "store empty after insert")
    `OSTK_ASSERT(a_count_cap, r_count <= CW'(CAPACITY), "count above capacity")
    `OSTK_ASSERT_ALWAYS(a_rst_clears, !i_rst_n |=> (r_count == '0), "count kept through reset")

endmodule

FILE: tb/outlier_score_top_k_unit_tb.sv
// Self-checking testbench for the outlier score top-k unit.
// Needs ostk_pkg and outlier_score_top_k_unit; directed table, then random phases,
// every drain result checked against a scoring and ranking model or a hand-written one.
`timescale 1ns / 100ps

module outlier_score_top_k_unit_tb;
    import ostk_pkg::*;

    localparam int SETTLE_CYCLES = 12;   // covers the observe pipeline, plus margin
    localparam int HOLD_CYCLES   = 300;  // long sink stall for back-pressure
    localparam int RANDOM_ITEMS  = 350;
    localparam int STORE_DEPTH   = 32;   // CAPACITY of the instance

    // index past the register list; the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam t_score ONE_SQ = 64'h0000_0001_0000_0000;  // deviation 1.0, squared
    localparam t_score SAT_SQ = 64'h3FFF_FFFF_0000_0001;  // saturated deviation, squared

    // one row of the stimulus plan: a register write or a stream item
    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        t_word                reg_data;
        logic                 cmd;
        t_row                 row;
        t_word                va;
        t_word                vb;
        t_word                vc;
        logic [2:0]           pres;     // {c, b, a}
        bit                   typed;    // drain with hand-written single result
        t_row                 e_row;
        t_score               e_score;
        logic                 e_valid;
    } t_plan_step;

    typedef struct {
        t_row   row;
        t_score score;
        logic   valid;
        logic   last;
    } t_kept;

    typedef struct {
        t_score score;
        t_row   row;
    } t_slot;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    t_word                 i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    // model state: registers and the ranked store
    t_word               mean_q [3];
    t_word               inv_q  [3];
    logic [BUDGET_W-1:0] budget_q;
    t_slot               ranked[$];
    t_kept               due_results[$];

    t_plan_step plan[$];
    t_plan_step cur_step;       // item on the bus, for its typed expectation
    int         mismatches;
    bit         steady;         // no idling on either side
    bit         hold_req;       // ask the sink for one long stall

    outlier_score_top_k_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Scoring and ranking model
    // ---------------------------------------------------------------

    // ((value - mean) * inv)^2: exact 33-bit difference, magnitude times
    // Q8.24 scale, drop 16 bits, clamp to 31 bits, square into Q32.32
    function automatic t_score deviation_sq(t_word v, t_word m, t_word inv);
        logic signed [32:0] gap;
        logic [32:0]        span;
        logic [63:0]        prod;
        logic [63:0]        dev;
        gap  = $signed({v[31], v}) - $signed({m[31], m});
        span = gap[32] ? 33'(-gap) : 33'(gap);
        prod = {31'd0, span} * {32'd0, inv};
        dev  = prod >> 16;
        if (dev > 64'h7FFF_FFFF)
            dev = 64'h7FFF_FFFF;
        return dev * dev;
    endfunction

    // worst measure of a row; absent values and zero scales are skipped
    function automatic t_score row_score(t_word va, t_word vb, t_word vc, logic [2:0] pres);
        t_word  vals[3];
        t_score best;
        t_score s;
        vals = '{va, vb, vc};
        best = '0;
        for (int m = 0; m < 3; m++) begin
            if (inv_q[m] != '0 && pres[m]) begin
                s = deviation_sq(vals[m], mean_q[m], inv_q[m]);
                if (s > best)
                    best = s;
            end
        end
        return best;
    endfunction

    // sorted insert: after every entry with an equal or higher score
    function automatic void rank_insert(t_score s, t_row r);
        int    pos;
        t_slot ent;
        pos = 0;
        while (pos < ranked.size() && ranked[pos].score >= s)
            pos++;
        ent.score = s;
        ent.row   = r;
        ranked.insert(pos, ent);
    endfunction

    function automatic void observe_row(t_score s, t_row r);
        int eff;
        eff = (budget_q > STORE_DEPTH) ? STORE_DEPTH : int'(budget_q);
        if (eff == 0 || s == '0)
            return;
        if (ranked.size() < eff) begin
            rank_insert(s, r);
        end else if (ranked.size() > 0 && s > ranked[$].score) begin
            // lowest is the tail; the newest among equal lowest sits last
            void'(ranked.pop_back());
            rank_insert(s, r);
        end
    endfunction

    function automatic void drain_rank();
        t_kept k;
        if (ranked.size() == 0) begin
            k = '{row: '0, score: '0, valid: 1'b0, last: 1'b1};
            due_results.insert(due_results.size(), k);
        end
        foreach (ranked[i]) begin
            k = '{row: ranked[i].row, score: ranked[i].score, valid: 1'b1,
                  last: (i == ranked.size() - 1)};
            due_results.insert(due_results.size(), k);
        end
        ranked.delete();
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, t_word data);
        case (idx)
            CFG_MEAN_A: mean_q[0] = data;
            CFG_MEAN_B: mean_q[1] = data;
            CFG_MEAN_C: mean_q[2] = data;
            CFG_INV_A:  inv_q[0]  = data;
            CFG_INV_B:  inv_q[1]  = data;
            CFG_INV_C:  inv_q[2]  = data;
            CFG_BUDGET: budget_q  = data[BUDGET_W-1:0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Monitors: predict on each input transfer, check each output transfer
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin : take_input
        int    base;
        t_kept hand;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            if (i_s_axis_tuser == CMD_DRAIN) begin
                base = due_results.size();
                drain_rank();
                if (cur_step.typed) begin
                    // hand-written result replaces the modeled one
                    while (due_results.size() > base)
                        void'(due_results.pop_back());
                    hand = '{row: cur_step.e_row, score: cur_step.e_score,
                             valid: cur_step.e_valid, last: 1'b1};
                    due_results.insert(due_results.size(), hand);
                end
            end else begin
                observe_row(row_score(i_s_axis_tdata[63:32], i_s_axis_tdata[95:64],
                                      i_s_axis_tdata[127:96], i_s_axis_tdata[130:128]),
                            i_s_axis_tdata[31:0]);
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_output
        t_kept want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (due_results.size() == 0) begin
                report_mismatch("result with none due", o_m_axis_tdata[63:0], '0);
            end else begin
                want = due_results.pop_front();
                if (o_m_axis_tdata[31:0] != want.row)
                    report_mismatch("kept_row", o_m_axis_tdata[31:0], want.row);
                if (o_m_axis_tdata[95:32] != want.score)
                    report_mismatch("kept_score", o_m_axis_tdata[95:32], want.score);
                if (o_m_axis_tuser != want.valid)
                    report_mismatch("row_valid", o_m_axis_tuser, want.valid);
                if (o_m_axis_tlast != want.last)
                    report_mismatch("last", o_m_axis_tlast, want.last);
            end
        end
    end

    // ---------------------------------------------------------------
    // Sink: random tready, one long hold-off on request
    // ---------------------------------------------------------------

    initial begin : sink
        int k;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_m_axis_tready <= steady || ($urandom_range(99) >= 6);
        end
    end

    // ---------------------------------------------------------------
    // Source side tasks
    // ---------------------------------------------------------------

    task automatic push_item(input t_plan_step st);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 6) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= st.cmd;
        i_s_axis_tdata  <= {5'd0, st.pres, st.vc, st.vb, st.va, st.row};
        cur_step        <= st;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // drop valid, wait for every due result, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_word data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Plan builders and random pickers
    // ---------------------------------------------------------------

    function automatic void plan_add(t_plan_step st);
        plan.insert(plan.size(), st);
    endfunction

    function automatic t_plan_step f_obs(t_row r, t_word va, t_word vb, t_word vc,
                                         logic [2:0] pres);
        t_plan_step st;
        st = '{default: '0};
        st.cmd  = CMD_OBSERVE;
        st.row  = r;
        st.va   = va;
        st.vb   = vb;
        st.vc   = vc;
        st.pres = pres;
        return st;
    endfunction

    function automatic t_plan_step f_drain();
        t_plan_step st;
        st = '{default: '0};
        st.cmd = CMD_DRAIN;
        return st;
    endfunction

    function automatic t_plan_step f_drain_is(t_row r, t_score s, logic v);
        t_plan_step st;
        st = f_drain();
        st.typed   = 1'b1;
        st.e_row   = r;
        st.e_score = s;
        st.e_valid = v;
        return st;
    endfunction

    function automatic t_plan_step f_write(logic [CFG_IDX_W-1:0] idx, t_word data);
        t_plan_step st;
        st = '{default: '0};
        st.is_write = 1'b1;
        st.reg_idx  = idx;
        st.reg_data = data;
        return st;
    endfunction

    function automatic t_word pick_mean();
        case ($urandom_range(3))
            0:       return '0;
            1:       return $urandom_range(32'h2_0000) - 32'h1_0000;
            2:       return $urandom;
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic t_word pick_inv();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 7)
            return $urandom_range(32'h0400_0000, 32'h0040_0000);
        return $urandom;
    endfunction

    function automatic t_word pick_budget();
        int opts[10];
        opts = '{0, 1, 2, 3, 8, 31, 32, 33, 63, 0};
        opts[9] = $urandom_range(63);
        return opts[$urandom_range(9)];
    endfunction

    // mostly near the mean on a coarse grid so that scores tie often
    function automatic t_word roll_value(t_word m);
        int r;
        r = $urandom_range(19);
        if (r < 12)
            return m + (($urandom_range(8) - 4) * 32'h80);
        if (r < 17)
            return m + $urandom_range(32'h2_0000) - 32'h1_0000;
        return $urandom;
    endfunction

    function automatic t_plan_step roll_observe();
        t_row       r;
        logic [2:0] pres;
        case ($urandom_range(19))
            0:       r = '0;
            1:       r = '1;
            default: r = $urandom;
        endcase
        for (int m = 0; m < 3; m++)
            pres[m] = ($urandom_range(9) < 8);
        return f_obs(r, roll_value(mean_q[0]), roll_value(mean_q[1]),
                     roll_value(mean_q[2]), pres);
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial begin : stimulus
        int phase;
        int fed;
        int count;
        int drain_odds;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_OBSERVE;
        cur_step        = '{default: '0};
        mismatches      = 0;
        steady          = 1'b0;
        hold_req        = 1'b0;
        for (int m = 0; m < 3; m++) begin
            mean_q[m] = '0;
            inv_q[m]  = '0;
        end
        budget_q = BUDGET_RST;

        // reset state: all scales zero, so nothing scores
        plan_add(f_drain_is('0, '0, 1'b0));
        plan_add(f_obs(32'd5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 3'b111));
        plan_add(f_drain_is('0, '0, 1'b0));
        // a: unit scale; b: full-range mean with max scale; c: skipped
        plan_add(f_write(CFG_MEAN_A, 32'h0000_0000));
        plan_add(f_write(CFG_INV_A,  32'h0100_0000));
        plan_add(f_write(CFG_MEAN_B, 32'h8000_0000));
        plan_add(f_write(CFG_INV_B,  32'hFFFF_FFFF));
        plan_add(f_write(CFG_MEAN_C, 32'h7FFF_FFFF));
        plan_add(f_write(CFG_INV_C,  32'h0000_0000));
        plan_add(f_write(CFG_SPARE,  32'hDEAD_BEEF));
        // deviation of exactly 1.0, c present but its scale is zero
        plan_add(f_obs(32'd1, 32'h0000_0100, '0, 32'h8000_0000, 3'b101));
        plan_add(f_drain_is(32'd1, ONE_SQ, 1'b1));
        // widest difference, saturated deviation
        plan_add(f_obs(32'd2, '0, 32'h7FFF_FFFF, '0, 3'b010));
        plan_add(f_drain_is(32'd2, SAT_SQ, 1'b1));
        // absent value, then values equal to the mean: zero score, not kept
        plan_add(f_obs(32'd3, 32'h0000_0100, 32'h7FFF_FFFF, '0, 3'b100));
        plan_add(f_obs(32'd4, '0, 32'h8000_0000, 32'h7FFF_FFFF, 3'b111));
        plan_add(f_drain_is('0, '0, 1'b0));
        // ordering: equal scores, negative difference, max over measures
        plan_add(f_obs(32'd10, 32'h0000_0200, '0, '0, 3'b001));
        plan_add(f_obs(32'd11, 32'h0000_0200, '0, '0, 3'b001));
        plan_add(f_obs(32'd12, 32'h0000_0100, '0, '0, 3'b001));
        plan_add(f_obs(32'd13, 32'hFFFF_FD00, '0, '0, 3'b001));
        plan_add(f_obs(32'd14, 32'h8000_0000, 32'h8000_0001, '0, 3'b011));
        plan_add(f_drain());
        // budget 2: tie at a full store is dropped, a higher score evicts
        // the newest of the equal lowest
        plan_add(f_write(CFG_BUDGET, 32'd2));
        plan_add(f_obs(32'd20, 32'h0000_0100, '0, '0, 3'b001));
        plan_add(f_obs(32'd21, 32'h0000_0100, '0, '0, 3'b001));
        plan_add(f_obs(32'd22, 32'h0000_0100, '0, '0, 3'b001));
        plan_add(f_obs(32'd23, 32'h0000_0180, '0, '0, 3'b001));
        plan_add(f_drain());
        // budget 0 keeps nothing
        plan_add(f_write(CFG_BUDGET, 32'd0));
        plan_add(f_obs(32'd30, 32'h0000_0100, '0, '0, 3'b001));
        plan_add(f_drain_is('0, '0, 1'b0));
        // above capacity acts as capacity
        plan_add(f_write(CFG_BUDGET, 32'd63));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_write) begin
                settle();
                write_reg(plan[k].reg_idx, plan[k].reg_data);
            end else begin
                push_item(plan[k]);
            end
        end

        // random phases; the store carries across config changes, so a
        // lowered budget meets a fuller store
        phase = 0;
        fed   = 0;
        while (fed < RANDOM_ITEMS) begin
            settle();
            steady = (phase == 2);
            if (phase == 0 || $urandom_range(9) < 6) write_reg(CFG_MEAN_A, pick_mean());
            if (phase == 0 || $urandom_range(9) < 6) write_reg(CFG_MEAN_B, pick_mean());
            if (phase == 0 || $urandom_range(9) < 6) write_reg(CFG_MEAN_C, pick_mean());
            if (phase == 0 || $urandom_range(9) < 6) write_reg(CFG_INV_A, pick_inv());
            if (phase == 0 || $urandom_range(9) < 6) write_reg(CFG_INV_B, pick_inv());
            if (phase == 0 || $urandom_range(9) < 6) write_reg(CFG_INV_C, pick_inv());
            if ($urandom_range(9) == 0) write_reg(CFG_SPARE, $urandom);
            write_reg(CFG_BUDGET, pick_budget());

            // alternate frequent drains with rare ones that fill the store
            drain_odds = (phase % 2 == 1) ? 6 : 40;
            if (phase == 4) begin
                hold_req   = 1'b1;
                drain_odds = 4;
            end
            count = $urandom_range(50, 25);
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(drain_odds - 1) == 0)
                    push_item(f_drain());
                else
                    push_item(roll_observe());
            end
            fed += count;
            phase++;
        end
        steady = 1'b0;
        push_item(f_drain());

        settle();
        if (mismatches == 0) begin
            $display("PASS outlier_score_top_k_unit");
        end else begin
            $display("FAIL outlier_score_top_k_unit");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #4_000_000;
        $display("timeout: results still due %0d", due_results.size());
        $display("FAIL outlier_score_top_k_unit");
        $finish;
    end

endmodule
